### hw/rtl/mbed_pkg.sv
// ----------------------------------------------------------------------------
// mbed_pkg
// Types and constants shared by the motion burst end detector.
// ----------------------------------------------------------------------------
package mbed_pkg;

    localparam int AXIS_W     = 16;
    localparam int SQSUM_W    = 32;
    localparam int RAD_W      = 40;
    localparam int MAG_W      = 20;
    localparam int REM_W      = 21;
    localparam int COUNT_W    = 11;
    localparam int RUN_W      = 8;
    localparam int THR_W      = 20;
    localparam int SETTLE_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int AXES       = 3;
    localparam int ROOT_STEPS = 20;
    localparam int STEP_W     = 5;

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(56);
    localparam logic [RUN_W-1:0]    RUN_RESET    = RUN_W'(5);
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(12);
    localparam logic [COUNT_W-1:0]  MAX_RESET    = COUNT_W'(256);
    localparam logic [RUN_W-1:0]    RUN_MAX      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_THRESHOLD = 2'd0,
        CFG_REQUIRED_RUN   = 2'd1,
        CFG_SETTLE_SAMPLES = 2'd2,
        CFG_MAX_SAMPLES    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     start_capture;
    } sample_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [COUNT_W-1:0] sample_number;
        logic               wave_end;
        logic               capture_full;
    } result_t;

    typedef struct packed {
        logic [THR_W-1:0]    near_threshold;
        logic [RUN_W-1:0]    required_run;
        logic [SETTLE_W-1:0] settle_samples;
        logic [COUNT_W-1:0]  max_samples;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic sum_en;
        logic commit;
    } win_ctrl_t;

endpackage

### hw/rtl/mbed_stream_if.sv
// ----------------------------------------------------------------------------
// mbed_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface mbed_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/motion_burst_end_detector.sv
// ----------------------------------------------------------------------------
// motion_burst_end_detector
// Three-axis sample in, magnitude and end-of-wave flags out.
// ----------------------------------------------------------------------------
// One sample is taken at a time and each gives exactly one result beat.
// From acceptance to the next acceptance a sample goes through these steps:
// the axes are squared one at a time on one shared 16x16 multiplier, the
// square root runs two radicand bits per cycle, the root is handed over
// through a register, the rolling window is updated and the wave end is
// decided, and the idle state takes the next sample. The
// finished result waits in an output register, so the next sample starts
// while it is still waiting; a sample finishing before the previous result
// is taken holds until that beat goes. start_capture clears the window,
// the sum, the run and the sample count before its own sample is counted.
// Configuration writes are meant for idle periods only.
module motion_burst_end_detector #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mbed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbed_pkg::CFG_DATA_W-1:0]   cfg_data,
    mbed_stream_if.sink                       samples,
    mbed_stream_if.source                     results
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAG  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_CMP  = 4'b1000
    } top_state_t;

    top_state_t                  state_reg, state_next;
    mbed_pkg::cfg_t              cfg_reg;
    mbed_pkg::result_t           result_reg;
    logic                        out_valid_reg;

    mbed_pkg::sample_t           sample;
    mbed_pkg::result_t           win_result;
    mbed_pkg::win_ctrl_t         ctrl;
    logic [mbed_pkg::MAG_W-1:0]  magnitude;
    logic                        mag_done;
    logic                        accept;
    logic                        can_load;

    assign sample   = samples.data;
    assign accept   = samples.valid && samples.ready;
    assign can_load = !out_valid_reg || results.ready;

    assign samples.ready = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = result_reg;

    assign ctrl.accept = accept;
    assign ctrl.clear  = sample.start_capture;
    assign ctrl.sum_en = (state_reg == ST_SUM);
    assign ctrl.commit = (state_reg == ST_CMP) && can_load;

    mbed_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .accel_x   (sample.accel_x),
        .accel_y   (sample.accel_y),
        .accel_z   (sample.accel_z),
        .done      (mag_done),
        .magnitude (magnitude)
    );

    mbed_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .magnitude (magnitude),
        .result    (win_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (mag_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            result_reg <= win_result;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= mbed_pkg::THR_RESET;
            cfg_reg.required_run   <= mbed_pkg::RUN_RESET;
            cfg_reg.settle_samples <= mbed_pkg::SETTLE_RESET;
            cfg_reg.max_samples    <= mbed_pkg::MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (mbed_pkg::cfg_index_t'(cfg_index))
                mbed_pkg::CFG_NEAR_THRESHOLD:
                begin
                    cfg_reg.near_threshold <= cfg_data[mbed_pkg::THR_W-1:0];
                end
                mbed_pkg::CFG_REQUIRED_RUN:
                begin
                    cfg_reg.required_run <= cfg_data[mbed_pkg::RUN_W-1:0];
                end
                mbed_pkg::CFG_SETTLE_SAMPLES:
                begin
                    cfg_reg.settle_samples <= cfg_data[mbed_pkg::SETTLE_W-1:0];
                end
                mbed_pkg::CFG_MAX_SAMPLES:
                begin
                    cfg_reg.max_samples <= cfg_data[mbed_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

### hw/rtl/mbed_ram.sv
// ----------------------------------------------------------------------------
// mbed_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/mbed_mag.sv
// ----------------------------------------------------------------------------
// mbed_mag
// Vector magnitude in Q16.4: one axis squared per cycle, then a
// radix-2 restoring square root taking two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mbed_mag (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mbed_pkg::AXIS_W-1:0]  accel_x,
    input  logic signed [mbed_pkg::AXIS_W-1:0]  accel_y,
    input  logic signed [mbed_pkg::AXIS_W-1:0]  accel_z,
    output logic                                done,
    output logic [mbed_pkg::MAG_W-1:0]          magnitude
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SQUARE = 3'b010,
        ST_ROOT   = 3'b100
    } mag_state_t;

    localparam int AXES_W = mbed_pkg::AXES * mbed_pkg::AXIS_W;

    mag_state_t                        state_reg, state_next;
    logic [mbed_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [AXES_W-1:0]                 axes_reg, axes_next;
    logic [mbed_pkg::RAD_W-1:0]        rad_reg, rad_next;
    logic [mbed_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [mbed_pkg::MAG_W-1:0]        root_reg, root_next;
    logic                              done_reg, done_next;

    logic signed [mbed_pkg::AXIS_W-1:0]    axis;
    logic signed [2*mbed_pkg::AXIS_W-1:0]  square;
    logic [mbed_pkg::SQSUM_W-1:0]          sqsum;
    logic [mbed_pkg::REM_W+1:0]            cand;
    logic [mbed_pkg::REM_W+1:0]            trial;

    assign axis   = axes_reg[AXES_W-1 -: mbed_pkg::AXIS_W];
    assign square = axis * axis;
    assign sqsum  = rad_reg[mbed_pkg::RAD_W-1 -: mbed_pkg::SQSUM_W]
                    + mbed_pkg::SQSUM_W'(unsigned'(square));
    assign cand   = {rem_reg, rad_reg[mbed_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        axes_next  = axes_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    axes_next  = {accel_x, accel_y, accel_z};
                    rad_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                rad_next  = {sqsum, 8'b0};
                axes_next = {axes_reg[AXES_W-mbed_pkg::AXIS_W-1:0],
                             {mbed_pkg::AXIS_W{1'b0}}};
                if (step_reg == mbed_pkg::STEP_W'(mbed_pkg::AXES - 1))
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                rad_next = {rad_reg[mbed_pkg::RAD_W-3:0], 2'b00};
                if (cand >= trial)
                begin
                    rem_next  = mbed_pkg::REM_W'(cand - trial);
                    root_next = {root_reg[mbed_pkg::MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = mbed_pkg::REM_W'(cand);
                    root_next = {root_reg[mbed_pkg::MAG_W-2:0], 1'b0};
                end
                if (step_reg == mbed_pkg::STEP_W'(mbed_pkg::ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axes_reg <= axes_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done      = done_reg;
    assign magnitude = root_reg;

endmodule

### hw/rtl/mbed_window.sv
// ----------------------------------------------------------------------------
// mbed_window
// Capture bookkeeping: sample count, rolling window with running sum,
// near-average run counter and the end-of-wave decision.
// ----------------------------------------------------------------------------
module mbed_window #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbed_pkg::win_ctrl_t         ctrl,
    input  mbed_pkg::cfg_t              cfg,
    input  logic [mbed_pkg::MAG_W-1:0]  magnitude,
    output mbed_pkg::result_t           result
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = mbed_pkg::MAG_W + PTR_W;

    logic [mbed_pkg::COUNT_W-1:0] count_reg;
    logic [mbed_pkg::COUNT_W-1:0] count1_reg;
    logic [PTR_W-1:0]             ptr_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_new_reg;
    logic [SUM_W-1:0]             scaled_reg;
    logic [mbed_pkg::RUN_W-1:0]   run_reg;
    logic [WINDOW_DEPTH-1:0]      valid_reg;

    logic [mbed_pkg::MAG_W-1:0]   rd_data;
    logic [mbed_pkg::MAG_W-1:0]   old_mag;
    logic [SUM_W-1:0]             diff;
    logic [SUM_W-1:0]             thr_scaled;
    logic [mbed_pkg::RUN_W-1:0]   run_next;
    logic                         detect;
    logic                         near;
    logic                         wave_end;
    logic                         full;
    logic                         ram_we;

    mbed_ram #(
        .WIDTH (mbed_pkg::MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ptr_reg),
        .wr_data (magnitude),
        .rd_en   (ctrl.accept),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign old_mag    = valid_reg[ptr_reg] ? rd_data : '0;
    assign detect     = count1_reg > mbed_pkg::COUNT_W'(cfg.settle_samples);
    assign diff       = (scaled_reg >= sum_new_reg) ? scaled_reg - sum_new_reg
                                                    : sum_new_reg - scaled_reg;
    assign thr_scaled = SUM_W'(cfg.near_threshold) * SUM_W'(WINDOW_DEPTH);
    assign near       = diff < thr_scaled;
    assign run_next   = !near ? '0
                      : (run_reg == mbed_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;
    assign wave_end   = detect && (run_next >= cfg.required_run);
    assign full       = count1_reg >= cfg.max_samples;
    assign ram_we     = ctrl.commit && detect;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            run_reg   <= '0;
            valid_reg <= '0;
        end
        else if ((ctrl.accept && ctrl.clear) || (ctrl.commit && (wave_end || full)))
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            run_reg   <= '0;
            valid_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            count_reg <= count1_reg;
            if (detect)
            begin
                sum_reg            <= sum_new_reg;
                run_reg            <= run_next;
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= (ptr_reg == PTR_W'(WINDOW_DEPTH - 1))
                                      ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            count1_reg  <= count_reg + 1'b1;
            sum_new_reg <= sum_reg - SUM_W'(old_mag) + SUM_W'(magnitude);
            scaled_reg  <= SUM_W'(magnitude) * SUM_W'(WINDOW_DEPTH);
        end
    end

    assign result.magnitude     = magnitude;
    assign result.sample_number = count1_reg;
    assign result.wave_end      = wave_end;
    assign result.capture_full  = full;

endmodule
